[rtl/lru_move_to_front_cache_macros.svh]
// Assertion helpers shared by the checking code of the cache.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef LRU_MOVE_TO_FRONT_CACHE_MACROS_SVH
`define LRU_MOVE_TO_FRONT_CACHE_MACROS_SVH

// Same-cycle implication.
`define LMTF_CHECK(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define LMTF_CHECK_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/lmtf_pkg.sv]
package lmtf_pkg;

    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 64;
    localparam int HPOS_W  = 4;
    localparam int COUNT_W = 32;
    localparam int CAP_W   = 5;

    localparam int ENTRIES_DEF    = 16;
    localparam int BLOCK_BITS_DEF = 64;
    localparam int CAP_RESET      = 16;
    localparam int HIT_POS_MAX    = 15;

    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PROBE = 2'd2;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic lookup;   // capture the key compare result
        logic move;     // cells at or below the slot take their left neighbor
    } cell_ctl_t;

endpackage

[rtl/lmtf_cell.sv]
module lmtf_cell #(
    parameter int IDX        = 0,
    parameter int ENTRIES    = 16,
    parameter int BLOCK_BITS = 64,
    localparam int POS_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
    input  logic                     clk,
    input  lmtf_pkg::cell_ctl_t      ctl,
    input  logic [POS_W-1:0]         slot,
    input  logic [CNT_W-1:0]         filled,
    input  logic [lmtf_pkg::KEY_W-1:0] req_key,
    input  logic [lmtf_pkg::KEY_W-1:0] left_key,
    input  logic [BLOCK_BITS-1:0]    left_block,
    output logic [lmtf_pkg::KEY_W-1:0] key,
    output logic [BLOCK_BITS-1:0]    block,
    output logic                     match
);
    import lmtf_pkg::*;

    logic [KEY_W-1:0]      key_reg;
    logic [BLOCK_BITS-1:0] block_reg;
    logic                  match_reg;
    logic                  take_left;
    logic                  is_filled;

    assign is_filled = (CNT_W'(IDX) < filled);
    assign take_left = ctl.move && (POS_W'(IDX) <= slot);

    // Hold the compare result until the update step consumes it.
    always_ff @(posedge clk)
    begin
        if (ctl.lookup)
        begin
            match_reg <= is_filled && (key_reg == req_key);
        end
        if (take_left)
        begin
            key_reg   <= left_key;
            block_reg <= left_block;
        end
    end

    assign key   = key_reg;
    assign block = block_reg;
    assign match = match_reg;

endmodule

[rtl/lru_move_to_front_cache.sv]
// Fully associative record cache of ENTRIES cells kept in recency order, cell 0
// holding the most recent key. A request (func, key, data_in) runs in a lookup
// step and an update step: in the lookup step every cell compares its key with
// the request key in parallel and registers the result; in the update step the
// first matching filled cell is selected, the result is loaded into the output
// register, and for a read hit or a write the chain shifts one step so the
// touched entry lands in cell 0. A new request is taken in the same cycle as the
// update of the previous one, not before; the update waits only while the
// output register still holds an untaken result. Read (func 0) returns the block
// and promotes on a hit; write (func 1) promotes a present key, appends an
// absent one while there is room, and otherwise replaces the least recent entry
// and flags an eviction; probe (func 2, and the unused code 3) changes nothing.
// Writing capacity (values 0 and above ENTRIES saturate to 1 and ENTRIES)
// empties the cache and clears the four wrapping counters; write it only while
// no request is in flight. There is no clearing pass after reset.
module lru_move_to_front_cache #(
    parameter int ENTRIES    = lmtf_pkg::ENTRIES_DEF,
    parameter int BLOCK_BITS = lmtf_pkg::BLOCK_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          capacity_we,
    input  logic [lmtf_pkg::CAP_W-1:0]    capacity,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lmtf_pkg::FUNC_W-1:0]   func,
    input  logic [lmtf_pkg::KEY_W-1:0]    key,
    input  logic [lmtf_pkg::DATA_W-1:0]   data_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [lmtf_pkg::DATA_W-1:0]   data_out,
    output logic [lmtf_pkg::HPOS_W-1:0]   hit_position,
    output logic                          evicted,
    output logic [lmtf_pkg::COUNT_W-1:0]  attempt_count,
    output logic [lmtf_pkg::COUNT_W-1:0]  hit_count,
    output logic [lmtf_pkg::COUNT_W-1:0]  write_count,
    output logic [lmtf_pkg::COUNT_W-1:0]  dispose_count
);
    import lmtf_pkg::*;

    localparam int POS_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CAP_RESET_LIVE = (CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    // Control state
    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   live_cap_reg;
    logic [CNT_W-1:0]   filled_reg;
    logic [COUNT_W-1:0] attempts_reg, hits_reg, writes_reg, disposals_reg;
    logic               out_valid_reg;

    // Request and result payload
    logic [FUNC_W-1:0]     req_func_reg;
    logic [KEY_W-1:0]      req_key_reg;
    logic [BLOCK_BITS-1:0] req_block_reg;
    logic                  hit_reg;
    logic [DATA_W-1:0]     data_out_reg;
    logic [HPOS_W-1:0]     hit_pos_reg;
    logic                  evicted_reg;

    // Cell chain
    cell_ctl_t             ctl;
    logic [KEY_W-1:0]      cell_key   [ENTRIES];
    logic [BLOCK_BITS-1:0] cell_block [ENTRIES];
    logic [KEY_W-1:0]      left_key   [ENTRIES];
    logic [BLOCK_BITS-1:0] left_block [ENTRIES];
    logic [ENTRIES-1:0]    match_vec;
    logic [ENTRIES-1:0]    first_hit;

    logic                  accept;
    logic                  update_fire;
    logic                  found;
    logic [POS_W-1:0]      pos;
    logic [BLOCK_BITS-1:0] sel_block;
    logic                  is_read, is_write;
    logic                  room;
    logic                  evict_c;
    logic [POS_W-1:0]      slot;
    logic [BLOCK_BITS-1:0] front_block;
    logic [HPOS_W-1:0]     hit_pos_c;
    logic [CNT_W-1:0]      live_cap_c;

    // Handshake: take a request when idle or when the current one retires.
    assign update_fire = (state_reg == ST_UPDATE) && (!out_valid_reg || !out_stall);
    assign in_stall    = !((state_reg == ST_IDLE) || update_fire);
    assign accept      = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (update_fire)
                begin
                    state_next = accept ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Pick the most recent matching cell; the match vector holds at most one
    // bit per filled key, the lowest index wins.
    assign first_hit = match_vec & (~match_vec + ENTRIES'(1));
    assign found     = |match_vec;

    always_comb
    begin
        pos       = '0;
        sel_block = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (first_hit[i])
            begin
                pos = pos | POS_W'(i);
            end
            sel_block = sel_block | (cell_block[i] & {BLOCK_BITS{first_hit[i]}});
        end
    end

    assign is_read  = (req_func_reg == FUNC_READ);
    assign is_write = (req_func_reg == FUNC_WRITE);
    assign room     = (filled_reg < live_cap_reg);
    assign evict_c  = is_write && !found && !room;

    // Slot that moves to the front: the hit, the next free cell, or the tail.
    always_comb
    begin
        if (found)
        begin
            slot = pos;
        end
        else if (room)
        begin
            slot = POS_W'(filled_reg);
        end
        else
        begin
            slot = POS_W'(live_cap_reg - CNT_W'(1));
        end
    end

    assign front_block = is_write ? req_block_reg : sel_block;

    assign ctl.lookup = (state_reg == ST_LOOKUP);
    assign ctl.move   = update_fire && (is_write || (is_read && found));

    // Saturate the reported position for caches deeper than the field.
    assign hit_pos_c = !found ? '0 :
                       (int'(pos) > HIT_POS_MAX) ? HPOS_W'(HIT_POS_MAX) : HPOS_W'(pos);

    // Clamp capacity into 1..ENTRIES at write time.
    always_comb
    begin
        if (capacity == '0)
        begin
            live_cap_c = CNT_W'(1);
        end
        else if (int'(capacity) > ENTRIES)
        begin
            live_cap_c = CNT_W'(ENTRIES);
        end
        else
        begin
            live_cap_c = CNT_W'(capacity);
        end
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign left_key[g]   = req_key_reg;
                assign left_block[g] = front_block;
            end
            else
            begin : g_body
                assign left_key[g]   = cell_key[g-1];
                assign left_block[g] = cell_block[g-1];
            end

            lmtf_cell #(
                .IDX        (g),
                .ENTRIES    (ENTRIES),
                .BLOCK_BITS (BLOCK_BITS)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .slot       (slot),
                .filled     (filled_reg),
                .req_key    (req_key_reg),
                .left_key   (left_key[g]),
                .left_block (left_block[g]),
                .key        (cell_key[g]),
                .block      (cell_block[g]),
                .match      (match_vec[g])
            );
        end
    endgenerate

    // Control registers: state, fill level, capacity and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            live_cap_reg  <= CNT_W'(CAP_RESET_LIVE);
            filled_reg    <= '0;
            attempts_reg  <= '0;
            hits_reg      <= '0;
            writes_reg    <= '0;
            disposals_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (capacity_we)
            begin
                live_cap_reg  <= live_cap_c;
                filled_reg    <= '0;
                attempts_reg  <= '0;
                hits_reg      <= '0;
                writes_reg    <= '0;
                disposals_reg <= '0;
            end
            else if (update_fire)
            begin
                if (is_read)
                begin
                    attempts_reg <= attempts_reg + COUNT_W'(1);
                    if (found)
                    begin
                        hits_reg <= hits_reg + COUNT_W'(1);
                    end
                end
                if (is_write)
                begin
                    writes_reg <= writes_reg + COUNT_W'(1);
                    if (!found && room)
                    begin
                        filled_reg <= filled_reg + CNT_W'(1);
                    end
                end
                if (evict_c)
                begin
                    disposals_reg <= disposals_reg + COUNT_W'(1);
                end
            end
            if (update_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and result register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_func_reg  <= func;
            req_key_reg   <= key;
            req_block_reg <= data_in[BLOCK_BITS-1:0];
        end
        if (update_fire)
        begin
            hit_reg      <= found;
            data_out_reg <= (is_read && found) ? DATA_W'(sel_block) : '0;
            hit_pos_reg  <= hit_pos_c;
            evicted_reg  <= evict_c;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign data_out      = data_out_reg;
    assign hit_position  = hit_pos_reg;
    assign evicted       = evicted_reg;
    // Counters move only when a result is loaded, so they match the pending result.
    assign attempt_count = attempts_reg;
    assign hit_count     = hits_reg;
    assign write_count   = writes_reg;
    assign dispose_count = disposals_reg;

`include "lru_move_to_front_cache_macros.svh"

    `LMTF_CHECK(a_fill_in_range, 1'b1, filled_reg <= live_cap_reg, "fill level above capacity")
    `LMTF_CHECK_NEXT(a_accept_to_lookup, accept, state_reg == ST_LOOKUP, "accepted request not in lookup")
    `LMTF_CHECK(a_result_after_update, out_valid_reg && !$past(out_valid_reg), $past(state_reg == ST_UPDATE), "result without update")
    `LMTF_CHECK_NEXT(a_read_counts, update_fire && is_read && !capacity_we, attempts_reg == $past(attempts_reg) + COUNT_W'(1), "read not counted")

endmodule

[tb/tb_lru_move_to_front_cache.sv]
`timescale 1ns / 100ps

module tb_lru_move_to_front_cache;

    import lmtf_pkg::*;

    // The spare func encoding; the block treats it as a probe.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int SETTLE_CYCLES = 10;

    // One result as it leaves the block, field for field.
    typedef struct packed {
        logic               hit;
        logic [DATA_W-1:0]  data_out;
        logic [HPOS_W-1:0]  hit_position;
        logic               evicted;
        logic [COUNT_W-1:0] attempts;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] writes;
        logic [COUNT_W-1:0] disposals;
    } cache_result_t;

    // Recency-ordered cache image: slot 0 is the most recent entry. Each noted
    // request updates the image and queues the result the block must return.
    class lru_cache_scoreboard;
        logic [KEY_W-1:0]   slot_key[ENTRIES_DEF];
        logic [DATA_W-1:0]  slot_block[ENTRIES_DEF];
        int unsigned        filled;
        int unsigned        live_cap;
        logic [COUNT_W-1:0] attempts, hits, writes, disposals;
        cache_result_t      expected_q[$];
        int unsigned        errors;

        function void set_capacity(logic [CAP_W-1:0] value);
            live_cap = (value == 0) ? 1 : ((value > ENTRIES_DEF) ? ENTRIES_DEF : value);
            filled = 0;
            attempts = '0;
            hits = '0;
            writes = '0;
            disposals = '0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Shift slots above pos down by one and land the entry at slot 0.
        function void move_front(int unsigned pos);
            logic [KEY_W-1:0]  k;
            logic [DATA_W-1:0] b;
            k = slot_key[pos];
            b = slot_block[pos];
            for (int i = pos; i > 0; i--)
            begin
                slot_key[i] = slot_key[i-1];
                slot_block[i] = slot_block[i-1];
            end
            slot_key[0] = k;
            slot_block[0] = b;
        endfunction

        function void note_request(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                   logic [DATA_W-1:0] d);
            int unsigned   n, pos, slot;
            bit            found;
            cache_result_t r;
            n = (filled > live_cap) ? live_cap : filled;
            found = 0;
            pos = 0;
            r = '0;
            for (int i = 0; i < n; i++)
            begin
                if (!found && slot_key[i] == k)
                begin
                    found = 1;
                    pos = i;
                end
            end
            case (f)
                FUNC_READ:
                begin
                    attempts++;
                    if (found)
                    begin
                        r.data_out = slot_block[pos];
                        move_front(pos);
                        hits++;
                    end
                end
                FUNC_WRITE:
                begin
                    writes++;
                    slot = pos;
                    if (!found)
                    begin
                        if (n < live_cap)
                        begin
                            slot = n;
                            filled = n + 1;
                        end
                        else
                        begin
                            slot = live_cap - 1;
                            disposals++;
                            r.evicted = 1'b1;
                        end
                        slot_key[slot] = k;
                    end
                    move_front(slot);
                    slot_block[0] = d;
                end
                default: ;  // probe and the spare code leave the cache untouched
            endcase
            r.hit = found;
            r.hit_position = found ? HPOS_W'((pos > HIT_POS_MAX) ? HIT_POS_MAX : pos) : '0;
            r.attempts = attempts;
            r.hits = hits;
            r.writes = writes;
            r.disposals = disposals;
            expected_q.push_back(r);
        endfunction

        function void check_result(cache_result_t got);
            cache_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.hit !== want.hit)
            begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.data_out !== want.data_out)
            begin
                $error("data_out: expected %h, got %h", want.data_out, got.data_out);
                errors++;
            end
            if (got.hit_position !== want.hit_position)
            begin
                $error("hit_position: expected %0d, got %0d",
                       want.hit_position, got.hit_position);
                errors++;
            end
            if (got.evicted !== want.evicted)
            begin
                $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                errors++;
            end
            if (got.attempts !== want.attempts)
            begin
                $error("attempt_count: expected %0d, got %0d",
                       want.attempts, got.attempts);
                errors++;
            end
            if (got.hits !== want.hits)
            begin
                $error("hit_count: expected %0d, got %0d", want.hits, got.hits);
                errors++;
            end
            if (got.writes !== want.writes)
            begin
                $error("write_count: expected %0d, got %0d", want.writes, got.writes);
                errors++;
            end
            if (got.disposals !== want.disposals)
            begin
                $error("dispose_count: expected %0d, got %0d",
                       want.disposals, got.disposals);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               capacity_we = 1'b0;
    logic [CAP_W-1:0]   capacity = CAP_W'(CAP_RESET);
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [FUNC_W-1:0]  func = FUNC_PROBE;
    logic [KEY_W-1:0]   key = '0;
    logic [DATA_W-1:0]  data_in = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               hit;
    logic [DATA_W-1:0]  data_out;
    logic [HPOS_W-1:0]  hit_position;
    logic               evicted;
    logic [COUNT_W-1:0] attempt_count;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] write_count;
    logic [COUNT_W-1:0] dispose_count;

    lru_cache_scoreboard sb;
    bit                  quiet = 1'b0;  // no idling on either side once set
    int unsigned         cycles = 0;

    lru_move_to_front_cache u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .capacity_we   (capacity_we),
        .capacity      (capacity),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .key           (key),
        .data_in       (data_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .data_out      (data_out),
        .hit_position  (hit_position),
        .evicted       (evicted),
        .attempt_count (attempt_count),
        .hit_count     (hit_count),
        .write_count   (write_count),
        .dispose_count (dispose_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case a request or a result never gets through.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Take every result the block hands over and compare it with the oldest
    // outstanding expectation. Signals are read before this edge's updates land.
    always @(posedge clk)
    begin : result_monitor
        cache_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{hit, data_out, hit_position, evicted,
                    attempt_count, hit_count, write_count, dispose_count};
            sb.check_result(got);
        end
    end

    // Receiver back-pressure: each random stretch stalls with a chance of one in three
    // (none once quiet is set), so stalls land on every phase of the pipeline.
    initial
    begin : result_stall
        bit stall_now;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall_now = !quiet && ($urandom_range(0, 2) == 0);
            out_stall <= stall_now;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    end

    // Present one request and hold it until the block takes it. An optional
    // idle burst comes first; valid drops only for that burst.
    task automatic send_request(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                logic [DATA_W-1:0] d);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        key <= k;
        data_in <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(f, k, d);
    endtask

    // Capacity may only change with nothing in flight: drain all results, give
    // the pipeline time to settle, then write the register.
    task automatic set_capacity(logic [CAP_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        capacity_we <= 1'b1;
        capacity <= value;
        @(posedge clk);
        capacity_we <= 1'b0;
        sb.set_capacity(value);
    endtask

    // Random traffic on one capacity setting. Most keys come from a pool up to four
    // keys larger than the capacity, so reads and writes keep hitting and evicting;
    // the rest are full-range keys that almost always miss.
    task automatic run_traffic(logic [CAP_W-1:0] cap_value, int unsigned count);
        logic [KEY_W-1:0]  key_pool[$];
        int unsigned       pool_size, pick;
        logic [FUNC_W-1:0] f;
        logic [KEY_W-1:0]  k;
        logic [DATA_W-1:0] d;
        set_capacity(cap_value);
        pool_size = ((cap_value == 0) ? 1 : ((cap_value > ENTRIES_DEF) ? ENTRIES_DEF
                                                                        : cap_value))
                    + $urandom_range(0, 4);
        repeat (pool_size) key_pool.push_back($urandom);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      f = FUNC_READ;
            else if (pick < 80) f = FUNC_WRITE;
            else if (pick < 95) f = FUNC_PROBE;
            else                f = FUNC_UNUSED;
            if ($urandom_range(0, 9) == 0) k = $urandom;
            else k = key_pool[$urandom_range(0, pool_size - 1)];
            pick = $urandom_range(0, 19);
            if (pick == 0)      d = '0;
            else if (pick == 1) d = '1;
            else                d = {$urandom, $urandom};
            send_request(f, k, d);
        end
    endtask

    initial
    begin
        sb = new;
        sb.set_capacity(CAP_W'(CAP_RESET));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset capacity: misses on an empty cache, extreme keys and blocks,
        // hits at deeper positions with promotion, and a rewrite of a present key.
        send_request(FUNC_READ, 32'h0000_0000, 64'h0);
        send_request(FUNC_PROBE, 32'hFFFF_FFFF, 64'h0);
        send_request(FUNC_WRITE, 32'h0000_0000, 64'h0);
        send_request(FUNC_WRITE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_WRITE, 32'h1234_5678, 64'hA5A5_A5A5_A5A5_A5A5);
        send_request(FUNC_READ, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_READ, 32'hFFFF_FFFF, 64'h0);
        send_request(FUNC_PROBE, 32'h0000_0000, 64'h0);
        send_request(FUNC_UNUSED, 32'hFFFF_FFFF, 64'h1);
        send_request(FUNC_WRITE, 32'h0000_0000, 64'h5A5A_5A5A_5A5A_5A5A);
        send_request(FUNC_READ, 32'h1234_5678, 64'h0);
        send_request(FUNC_READ, 32'hDEAD_BEEF, 64'h0);

        // Capacity zero behaves as one entry: every new key evicts the last.
        set_capacity(5'd0);
        send_request(FUNC_WRITE, 32'h0000_00AA, 64'h1111_2222_3333_4444);
        send_request(FUNC_WRITE, 32'h0000_00BB, 64'h5555_6666_7777_8888);
        send_request(FUNC_READ, 32'h0000_00AA, 64'h0);
        send_request(FUNC_READ, 32'h0000_00BB, 64'h0);
        send_request(FUNC_UNUSED, 32'h0000_00BB, 64'h0);

        // Random phases: saturated capacity, the smallest ones, the reset value, five,
        // three random settings, then a final stretch without any idling.
        run_traffic(5'd31, 150);
        run_traffic(5'd1, 100);
        run_traffic(5'd16, 150);
        run_traffic(5'd2, 120);
        run_traffic(5'd5, 120);
        repeat (3) run_traffic(CAP_W'($urandom_range(0, 31)), 120);
        quiet = 1'b1;
        run_traffic(5'd16, 150);

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/lmtf_pkg.sv
rtl/lmtf_cell.sv
rtl/lru_move_to_front_cache.sv
tb/tb_lru_move_to_front_cache.sv
